@@ src/assert_macros.svh @@
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("next-cycle check failed");

`endif

@@ src/acfp_pkg.sv @@
package acfp_pkg;

  localparam int FrameBytes  = 8;
  localparam int HdrBytes    = 2;
  localparam int FillWidth   = $clog2(FrameBytes + 1);
  localparam int IdxWidth    = $clog2(FrameBytes);
  localparam int CrcBytes    = FrameBytes - 3;
  localparam int CrcCntWidth = $clog2(CrcBytes);
  localparam int CountWidth  = 32;
  localparam int PinWidth    = 4;
  localparam int OutFieldBits = 3 * PinWidth + 3 * CountWidth;
  localparam int OutDataWidth = ((OutFieldBits + 7) / 8) * 8;
  localparam int OutPad       = OutDataWidth - OutFieldBits;

  localparam logic [7:0] HdrFirst   = 8'hA5;
  localparam logic [7:0] HdrSecond  = 8'h5A;
  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] PayloadLen = 8'h01;
  localparam logic [PinWidth-1:0] PinInvert    = 4'h9;
  localparam logic [PinWidth-1:0] OutputsReset = 4'h1;
  localparam logic [PinWidth-1:0] LegacyBit    = 4'h1;

  localparam logic [7:0] ReceiverAddressReset = 8'h01;
  localparam logic [7:0] FrameTypeReset       = 8'h02;

  localparam int CfgIndexWidth = 2;
  localparam logic [CfgIndexWidth-1:0] CFG_RECEIVER_ADDRESS = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_FRAME_TYPE       = 2'd1;

  typedef struct packed {
    logic append;
    logic clear;
    logic shift;
    logic keep_tail;
    logic crc_start;
    logic crc_step;
    logic emit;
  } acfp_cmd_t;

  typedef struct packed {
    logic fill_lt2;
    logic fill_eq2;
    logic fill_full;
    logic hdr_at_front;
    logic crc_last;
    logic frame_good;
    logic out_free;
  } acfp_status_t;

  // MSB-first CRC-8 update over one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] popcount4(input logic [PinWidth-1:0] v);
    return {2'b00, v[0]} + {2'b00, v[1]} + {2'b00, v[2]} + {2'b00, v[3]};
  endfunction

endpackage

@@ src/aux_control_frame_parser_crc8.sv @@
// Auxiliary control frame parser with CRC-8 (poly 0x07) check.
// Input stream (s_*): one received byte per word, s_tuser flags a line error,
// which flushes the resync buffer and yields no result.
// Output stream (m_*): one word per frame check; m_tuser is 0 for an applied
// frame and 1 for a reject, m_tdata carries pin writes and running counters.
// Config channel (cfg_*): index 0 receiver address, index 1 frame type;
// ready whenever out of reset, other indexes are ignored.
// A byte that completes no frame passes from idle through the search state and
// back to idle. When a byte completes eight buffered bytes with the header at
// the front, the CRC loop runs over the bytes from address to payload, one
// buffered byte per cycle, and the emit state then writes the result word;
// after a reject the resync scan shifts the buffer one byte per cycle.
// s_tready is high only while the controller is idle and out of reset.
// If m_tready is low, a finished word waits in the output register; the next
// byte is still taken, and a second result waits in the controller until the
// register frees.
// Reset empties the buffer, sets the remembered outputs to 0x1, clears the
// counters and loads address 1 and type 2.
module aux_control_frame_parser_crc8 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [7:0]                         s_tdata,   // rx_byte
  input  logic                               s_tuser,   // line_error
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // pin_write_enable[3:0], pin_levels[7:4], pin_changes[11:8],
  // good_frame_count[43:12], bad_frame_count[75:44], switch_event_count[107:76]
  output logic [acfp_pkg::OutDataWidth-1:0]  m_tdata,
  output logic                               m_tuser,   // frame_event
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [acfp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]                         cfg_data
);
  import acfp_pkg::*;

  acfp_cmd_t    cmd;
  acfp_status_t stat;

  assign cfg_ready = !rst;

  acfp_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_line_error (s_tuser),
    .in_ready      (s_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  acfp_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_byte   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_event (m_tuser)
  );

`include "assert_macros.svh"

  `ASSERT_NEXT(a_busy_after_byte, clk, rst, s_tvalid && s_tready && !s_tuser, !s_tready)
  `ASSERT_IMPLIES(a_emit_slot_free, clk, rst, cmd.emit, stat.out_free)
  `ASSERT_NEXT(a_emit_shows_word, clk, rst, cmd.emit, m_tvalid)
  `ASSERT_IMPLIES(a_crc_on_full_frame, clk, rst, cmd.crc_start,
                  stat.hdr_at_front && stat.fill_full)

endmodule

@@ src/acfp_ctrl.sv @@
module acfp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_line_error,
  output logic                  in_ready,
  input  acfp_pkg::acfp_status_t stat,
  output acfp_pkg::acfp_cmd_t    cmd
);
  import acfp_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_CRC    = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_line_error) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.append = 1'b1;
            state_next = S_SEARCH;
          end
        end
      end
      S_SEARCH: begin
        // advance one byte at a time until the header sits at the front or under three bytes remain
        priority if (stat.fill_lt2) begin
          state_next = S_IDLE;
        end else if (stat.hdr_at_front) begin
          if (stat.fill_full) begin
            cmd.crc_start = 1'b1;
            state_next    = S_CRC;
          end else begin
            state_next = S_IDLE;
          end
        end else if (stat.fill_eq2) begin
          cmd.keep_tail = 1'b1;
          state_next    = S_IDLE;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      S_CRC: begin
        cmd.crc_step = 1'b1;
        if (stat.crc_last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output slot is free
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.frame_good ? S_IDLE : S_SEARCH;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ src/acfp_datapath.sv @@
module acfp_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  acfp_pkg::acfp_cmd_t                   cmd,
  output acfp_pkg::acfp_status_t                stat,
  input  logic [7:0]                            in_byte,
  input  logic                                  cfg_valid,
  input  logic [acfp_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [7:0]                            cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [acfp_pkg::OutDataWidth-1:0]     out_data,
  output logic                                  out_event
);
  import acfp_pkg::*;

  logic [7:0]             frame_buf [FrameBytes];
  logic [FillWidth-1:0]   fill;
  logic [7:0]             crc;
  logic [CrcCntWidth-1:0] crc_idx;
  logic [7:0]             receiver_address;
  logic [7:0]             control_frame_type;
  logic [PinWidth-1:0]    remembered;
  logic [CountWidth-1:0]  good_frames;
  logic [CountWidth-1:0]  bad_frames;
  logic [CountWidth-1:0]  switch_events;

  logic [PinWidth-1:0]    out_wen;
  logic [PinWidth-1:0]    out_lev;
  logic [PinWidth-1:0]    out_chg;

  logic                   hdr_ok;
  logic                   frame_good;
  logic                   drop_one;
  logic [IdxWidth-1:0]    crc_addr;
  logic [PinWidth-1:0]    bits;
  logic [PinWidth-1:0]    mask_raw;
  logic [PinWidth-1:0]    chg_raw;
  logic [PinWidth-1:0]    mask;
  logic [PinWidth-1:0]    chg;

  assign hdr_ok     = (frame_buf[0] == HdrFirst) && (frame_buf[1] == HdrSecond);
  assign frame_good = hdr_ok && (frame_buf[2] == receiver_address) &&
                      (frame_buf[3] == control_frame_type) &&
                      (frame_buf[4] == PayloadLen) &&
                      (crc == frame_buf[FrameBytes-1]);
  assign drop_one   = cmd.shift || (cmd.emit && !frame_good);
  assign crc_addr   = IdxWidth'(crc_idx) + IdxWidth'(HdrBytes);

  // payload byte: low nibble output bits, high nibble update mask
  assign bits     = frame_buf[6][PinWidth-1:0];
  assign mask_raw = frame_buf[6][7:4];
  assign chg_raw  = bits ^ remembered;
  assign mask     = (mask_raw == '0) ? (chg_raw | LegacyBit) : mask_raw;
  assign chg      = chg_raw & mask;

  always_comb begin
    stat.fill_lt2     = (fill < FillWidth'(2));
    stat.fill_eq2     = (fill == FillWidth'(2));
    stat.fill_full    = (fill == FillWidth'(FrameBytes));
    stat.hdr_at_front = hdr_ok;
    stat.crc_last     = (crc_idx == CrcCntWidth'(CrcBytes - 1));
    stat.frame_good   = frame_good;
    stat.out_free     = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      frame_buf[fill[IdxWidth-1:0]] <= in_byte;
    end else if (drop_one) begin
      for (int i = 0; i < FrameBytes - 1; i++) begin
        frame_buf[i] <= frame_buf[i+1];
      end
    end else if (cmd.keep_tail) begin
      frame_buf[0] <= HdrFirst;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      priority if (cmd.clear) begin
        fill <= '0;
      end else if (cmd.append) begin
        fill <= fill + FillWidth'(1);
      end else if (drop_one) begin
        fill <= fill - FillWidth'(1);
      end else if (cmd.emit) begin
        fill <= '0;
      end else if (cmd.keep_tail) begin
        // keep a lone trailing first header byte
        fill <= (frame_buf[1] == HdrFirst) ? FillWidth'(1) : FillWidth'(0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.crc_start) begin
      crc     <= '0;
      crc_idx <= '0;
    end else if (cmd.crc_step) begin
      crc     <= crc8_byte(crc, frame_buf[crc_addr]);
      crc_idx <= crc_idx + CrcCntWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiver_address   <= ReceiverAddressReset;
      control_frame_type <= FrameTypeReset;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_RECEIVER_ADDRESS) begin
        receiver_address <= cfg_data;
      end else if (cfg_index == CFG_FRAME_TYPE) begin
        control_frame_type <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remembered    <= OutputsReset;
      good_frames   <= '0;
      bad_frames    <= '0;
      switch_events <= '0;
    end else if (cmd.emit) begin
      if (frame_good) begin
        remembered    <= (remembered & ~mask) | (bits & mask);
        good_frames   <= good_frames + CountWidth'(1);
        switch_events <= switch_events + CountWidth'(popcount4(chg));
      end else begin
        bad_frames <= bad_frames + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_event <= !frame_good;
      out_wen   <= frame_good ? mask : '0;
      out_lev   <= frame_good ? (bits ^ PinInvert) : '0;
      out_chg   <= frame_good ? chg : '0;
    end
  end

  // counters are shown live; they change only on emit, so they stay with the word
  assign out_data = {{OutPad{1'b0}}, switch_events, bad_frames, good_frames,
                     out_chg, out_lev, out_wen};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import acfp_pkg::*;

  localparam int QuietLimit   = 2000;
  localparam int SettleCycles = 20;
  localparam int RandomBytes  = 220;
  localparam int IdlePercent  = 22;

  // Indexes that decode to no register.
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_LOW  = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CFG_SPARE_HIGH = 2'd3;

  typedef struct {
    bit        rejected;
    bit [3:0]  wen;
    bit [3:0]  lev;
    bit [3:0]  chg;
    bit [31:0] good;
    bit [31:0] bad;
    bit [31:0] sw;
  } frame_report_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [7:0]               s_tdata = 8'h00;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OutDataWidth-1:0]  m_tdata;
  logic                     m_tuser;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = CFG_RECEIVER_ADDRESS;
  logic [7:0]               cfg_data = 8'h00;

  // Shadow of the parser state.
  bit [7:0]      rx_buf[$];
  bit [7:0]      rx_addr = ReceiverAddressReset;
  bit [7:0]      frame_type = FrameTypeReset;
  bit [3:0]      pin_state = OutputsReset;
  bit [31:0]     good_total = 0;
  bit [31:0]     bad_total = 0;
  bit [31:0]     switch_total = 0;
  frame_report_t pending_reports[$];

  int n_errors = 0;
  int bytes_sent = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  aux_control_frame_parser_crc8 i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit [7:0] crc8_of(input bit [7:0] data[$], input int first,
                                       input int count);
    bit [7:0] c = 8'h00;
    for (int i = 0; i < count; i++) begin
      c ^= data[first + i];
      for (int k = 0; k < 8; k++) begin
        c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Advance the shadow parser by one byte and queue the frame reports it causes.
  function automatic void parse_byte(input bit [7:0] b, input bit err);
    int            h;
    bit [7:0]      last_b;
    bit [3:0]      bits;
    bit [3:0]      mask;
    bit [3:0]      chg;
    frame_report_t r;
    if (err) begin
      rx_buf.delete();
      return;
    end
    rx_buf.push_back(b);
    while (rx_buf.size() >= 2) begin
      h = 0;
      while (h + 1 < rx_buf.size() &&
             !(rx_buf[h] == HdrFirst && rx_buf[h + 1] == HdrSecond)) h++;
      if (h + 1 >= rx_buf.size()) begin
        // no header: keep only a trailing first header byte
        last_b = rx_buf[$];
        rx_buf.delete();
        if (last_b == HdrFirst) rx_buf.push_back(HdrFirst);
        break;
      end
      repeat (h) void'(rx_buf.pop_front());
      if (rx_buf.size() < FrameBytes) break;
      r = '{default: 0};
      if (rx_buf[2] == rx_addr && rx_buf[3] == frame_type && rx_buf[4] == PayloadLen &&
          crc8_of(rx_buf, 2, FrameBytes - 3) == rx_buf[FrameBytes - 1]) begin
        bits = rx_buf[6][3:0];
        mask = rx_buf[6][7:4];
        chg  = bits ^ pin_state;
        if (mask == 4'h0) mask = chg | LegacyBit;
        chg &= mask;
        pin_state = (pin_state & ~mask) | (bits & mask);
        switch_total += 32'($countones(chg));
        good_total++;
        r.wen = mask;
        r.lev = bits ^ PinInvert;
        r.chg = chg;
        repeat (FrameBytes) void'(rx_buf.pop_front());
      end else begin
        bad_total++;
        r.rejected = 1'b1;
        void'(rx_buf.pop_front());
      end
      r.good = good_total;
      r.bad  = bad_total;
      r.sw   = switch_total;
      pending_reports.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      n_errors++;
    end
  endfunction

  // Leave s_tvalid high after a word so the next byte can follow back to back.
  task automatic send_byte(input bit [7:0] b, input bit err);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= err;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    parse_byte(b, err);
    bytes_sent++;
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx, input bit [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RECEIVER_ADDRESS: rx_addr = val;
      CFG_FRAME_TYPE:       frame_type = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every report is in, then let the parser settle.
  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic send_frame(input bit [7:0] addr, input bit [7:0] ftype,
                            input bit [7:0] len, input bit [7:0] b5, input bit [7:0] b6,
                            input bit [7:0] crc_flip, input int keep);
    bit [7:0] f[$];
    f = {HdrFirst, HdrSecond, addr, ftype, len, b5, b6};
    f.push_back(crc8_of(f, 2, FrameBytes - 3) ^ crc_flip);
    for (int i = 0; i < keep; i++) send_byte(f[i], 1'b0);
  endtask

  // Mostly well-formed frames; the rest are bad fields, noise, cut frames and line errors.
  task automatic send_random_chunk();
    int       pick;
    bit [7:0] b5;
    bit [7:0] b6;
    bit [7:0] flip;
    bit [7:0] nb;
    pick = $urandom_range(99);
    b5   = 8'($urandom);
    b6   = 8'($urandom);
    flip = 8'($urandom_range(255, 1));
    if ($urandom_range(3) == 0) b6[7:4] = 4'h0;
    if (pick < 55) begin
      send_frame(rx_addr, frame_type, PayloadLen, b5, b6, 8'h00, FrameBytes);
    end else if (pick < 62) begin
      send_frame(rx_addr ^ flip, frame_type, PayloadLen, b5, b6, 8'h00, FrameBytes);
    end else if (pick < 69) begin
      send_frame(rx_addr, frame_type ^ flip, PayloadLen, b5, b6, 8'h00, FrameBytes);
    end else if (pick < 76) begin
      send_frame(rx_addr, frame_type, PayloadLen ^ flip, b5, b6, 8'h00, FrameBytes);
    end else if (pick < 84) begin
      send_frame(rx_addr, frame_type, PayloadLen, b5, b6, flip, FrameBytes);
    end else if (pick < 93) begin
      repeat ($urandom_range(6, 1)) begin
        case ($urandom_range(2))
          0:       nb = HdrFirst;
          1:       nb = HdrSecond;
          default: nb = 8'($urandom);
        endcase
        send_byte(nb, 1'b0);
      end
    end else if (pick < 97) begin
      send_frame(rx_addr, frame_type, PayloadLen, b5, b6, 8'h00, $urandom_range(7, 1));
      send_byte(8'($urandom), 1'b1);
    end else begin
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  task automatic test_directed_frames();
    // empty mask takes the changed bits plus bit 0; byte 5 at both extremes
    send_frame(rx_addr, frame_type, PayloadLen, 8'hFF, 8'h0F, 8'h00, FrameBytes);
    send_frame(rx_addr, frame_type, PayloadLen, 8'h00, 8'hF0, 8'h00, FrameBytes);
    send_frame(rx_addr, frame_type, PayloadLen, 8'($urandom), 8'($urandom), 8'h80,
               FrameBytes);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_register_settings();
    bit [7:0] a;
    bit [7:0] t;
    for (int p = 0; p < 4; p++) begin
      wait_for_results();
      case (p)
        0: begin a = 8'h00; t = 8'hFF; end
        1: begin a = 8'hFF; t = 8'h00; end
        2: begin a = 8'($urandom); t = 8'($urandom); end
        default: begin a = ReceiverAddressReset; t = FrameTypeReset; end
      endcase
      write_reg(CFG_RECEIVER_ADDRESS, a);
      write_reg(CFG_FRAME_TYPE, t);
      if (p == 0) begin
        // unknown indexes must leave both registers alone
        write_reg(CFG_SPARE_LOW, 8'hFF);
        write_reg(CFG_SPARE_HIGH, 8'($urandom));
      end
      repeat (6) send_random_chunk();
    end
  endtask

  task automatic test_random_stream();
    int start;
    bit paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < RandomBytes) begin
      no_idle = (bytes_sent - start >= 60 && bytes_sent - start < 140);
      if (!paused && bytes_sent - start >= 160) begin
        paused = 1'b1;
        wait_for_results();
        write_reg(CFG_RECEIVER_ADDRESS, 8'($urandom));
        write_reg(CFG_FRAME_TYPE, 8'($urandom));
      end
      send_random_chunk();
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= IdlePercent);
  end

  always @(posedge clk) begin : check_reports
    frame_report_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result word with no frame check pending");
        n_errors++;
      end else begin
        exp_r = pending_reports.pop_front();
        check_field("frame_event", 32'(exp_r.rejected), 32'(m_tuser));
        check_field("pin_write_enable", 32'(exp_r.wen), 32'(m_tdata[3:0]));
        check_field("pin_levels", 32'(exp_r.lev), 32'(m_tdata[7:4]));
        check_field("pin_changes", 32'(exp_r.chg), 32'(m_tdata[11:8]));
        check_field("good_frame_count", exp_r.good, m_tdata[43:12]);
        check_field("bad_frame_count", exp_r.bad, m_tdata[75:44]);
        check_field("switch_event_count", exp_r.sw, m_tdata[107:76]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_frames();
    test_register_settings();
    test_random_stream();
    wait_for_results();
    if (n_errors == 0 && pending_reports.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
